/* rtl/core/qte_pkg.sv */
// shared widths, constants and the cordic angle table for the quaternion to euler block
`default_nettype none
package qte_pkg;

  localparam int ARG_W     = 34;  // products and atan2 arguments, q28
  localparam int S_W       = 30;  // clamped arcsine argument
  localparam int RAD_W     = 57;  // radicand 2^56 - s^2
  localparam int SQ_W      = 58;  // working width of the square root
  localparam int ROOT_BITS = 29;  // root bits, root <= 2^28
  localparam int XW        = 36;  // cordic vector width
  localparam int ZW        = 34;  // cordic angle width, 2^-23 degree
  localparam int ATAN_LEN  = 24;

  localparam logic signed [ARG_W-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [ZW-1:0]    DEG90   = 34'sd754974720;
  localparam logic signed [ZW-1:0]    DEG180  = 34'sd1509949440;

  // atan(2^-i) in 2^-23 degree
  localparam logic [28:0] ATAN_TAB [ATAN_LEN] = '{
    29'd377487360, 29'd222843801, 29'd117744544, 29'd59768969, 29'd30000467,
    29'd15014858, 29'd7509261, 29'd3754860, 29'd1877459, 29'd938733,
    29'd469367, 29'd234683, 29'd117342, 29'd58671, 29'd29335, 29'd14668,
    29'd7334, 29'd3667, 29'd1833, 29'd917, 29'd458, 29'd229, 29'd115, 29'd57
  };

  typedef struct packed {
    logic signed [ARG_W-1:0] rn;
    logic signed [ARG_W-1:0] rd;
    logic signed [ARG_W-1:0] yn;
    logic signed [ARG_W-1:0] yd;
    logic signed [S_W-1:0]   s;
    logic                    clamp;
  } args_t;

endpackage
`default_nettype wire

/* rtl/core/quaternion_to_euler_angles.sv */
// top level: quaternion to zyx roll, pitch and yaw angles, fully pipelined
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i, in_ready_o, q_w/x/y/z_i   | input
//  out     | out_valid_o, out_ready_i, roll_deg_o, | output
//          | pitch_deg_o, yaw_deg_o, pitch_clamped_o |
//
// one item per cycle unless the output stalls; the path runs through the front stages,
// the 29 one-bit square root stages and the cordic fold, rotation and rounding stages
// reset clears only the valid bits, data registers hold whatever they held
// a stall at the output freezes every stage at once, so no item is lost
// the last cordic register is the output register
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_deg_o,
  output logic signed [14:0] pitch_deg_o,
  output logic signed [15:0] yaw_deg_o,
  output logic               pitch_clamped_o
);
  import qte_pkg::*;

  // cordic block latency: fold stage, rotations, rounding stage
  localparam int CLAT = ((CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS) + 2;

  logic en;
  logic fr_valid, sq_valid, pitch_valid, yaw_valid;
  args_t fr_args, sq_args;
  logic [RAD_W-1:0] rad;
  logic [ROOT_BITS-1:0] root;
  logic [CLAT-1:0] clamp_q;

  // whole pipeline advances unless a result is held at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  qte_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .q_w_i, .q_x_i, .q_y_i, .q_z_i,
    .valid_o(fr_valid), .args_o(fr_args), .rad_o(rad)
  );

  qte_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid),
    .rad_i(rad), .args_i(fr_args),
    .valid_o(sq_valid), .root_o(root), .args_o(sq_args)
  );

  // roll from atan2(2(wx+yz), 1-2(x^2+y^2))
  qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(23040), .OUT_W(16)) u_roll (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid),
    .y_i(sq_args.rn), .x_i(sq_args.rd),
    .valid_o(out_valid_o), .angle_o(roll_deg_o)
  );

  // pitch from atan2(s, sqrt(1-s^2))
  qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(11520), .OUT_W(15)) u_pitch (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid),
    .y_i(ARG_W'(sq_args.s)), .x_i($signed(ARG_W'(root))),
    .valid_o(pitch_valid), .angle_o(pitch_deg_o)
  );

  // yaw from atan2(2(wz+xy), 1-2(y^2+z^2))
  qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(23040), .OUT_W(16)) u_yaw (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid),
    .y_i(sq_args.yn), .x_i(sq_args.yd),
    .valid_o(yaw_valid), .angle_o(yaw_deg_o)
  );

  // clamp flag rides alongside the cordic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      clamp_q <= {clamp_q[CLAT-2:0], sq_args.clamp};
    end
  end

  assign pitch_clamped_o = clamp_q[CLAT-1];

`ifndef SYNTHESIS
  // the three angle pipelines stay in lock step
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o == pitch_valid) && (out_valid_o == yaw_valid))
    else $error("angle pipelines out of step");

  // a clamped argument gives pitch of exactly plus or minus 90 degrees
  a_clamp_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pitch_clamped_o |->
      (pitch_deg_o == 15'sd11520 || pitch_deg_o == -15'sd11520))
    else $error("clamped pitch not at the pole");

  // saturation keeps roll and yaw within half a turn
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_deg_o <= 16'sd23040) && (roll_deg_o >= -16'sd23040)
      && (yaw_deg_o <= 16'sd23040) && (yaw_deg_o >= -16'sd23040))
    else $error("roll or yaw out of range");
`endif

endmodule
`default_nettype wire

/* rtl/core/qte_front.sv */
// products, sums, arcsine clamp and square root radicand, three stages
`default_nettype none
module qte_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [15:0]          q_w_i,
  input  logic signed [15:0]          q_x_i,
  input  logic signed [15:0]          q_y_i,
  input  logic signed [15:0]          q_z_i,
  output logic                        valid_o,
  output qte_pkg::args_t              args_o,
  output logic [qte_pkg::RAD_W-1:0]   rad_o
);
  import qte_pkg::*;

  logic [2:0] v_q;
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_wy_q, p_zx_q, p_zz_q;
  args_t args2_d, args2_q, args3_q;
  logic signed [ARG_W-1:0] s_raw;
  logic signed [2*S_W-1:0] sq;
  logic [RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_wx_q <= q_w_i * q_x_i;
      p_yz_q <= q_y_i * q_z_i;
      p_xx_q <= q_x_i * q_x_i;
      p_yy_q <= q_y_i * q_y_i;
      p_wz_q <= q_w_i * q_z_i;
      p_xy_q <= q_x_i * q_y_i;
      p_wy_q <= q_w_i * q_y_i;
      p_zx_q <= q_z_i * q_x_i;
      p_zz_q <= q_z_i * q_z_i;
    end
  end

  // stage 2: sums and clamp
  always_comb begin
    args2_d.rn = (ARG_W'(p_wx_q) + ARG_W'(p_yz_q)) <<< 1;
    args2_d.rd = ONE_Q28 - ((ARG_W'(p_xx_q) + ARG_W'(p_yy_q)) <<< 1);
    args2_d.yn = (ARG_W'(p_wz_q) + ARG_W'(p_xy_q)) <<< 1;
    args2_d.yd = ONE_Q28 - ((ARG_W'(p_yy_q) + ARG_W'(p_zz_q)) <<< 1);
    s_raw      = (ARG_W'(p_wy_q) - ARG_W'(p_zx_q)) <<< 1;
    if (s_raw > ONE_Q28) begin
      args2_d.s     = S_W'(ONE_Q28);
      args2_d.clamp = 1'b1;
    end else if (s_raw < -ONE_Q28) begin
      args2_d.s     = S_W'(-ONE_Q28);
      args2_d.clamp = 1'b1;
    end else begin
      args2_d.s     = S_W'(s_raw);
      args2_d.clamp = 1'b0;
    end
  end

  // stage 3: radicand 2^56 - s^2
  assign sq = args2_q.s * args2_q.s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      args2_q <= args2_d;
      args3_q <= args2_q;
      rad_q   <= (RAD_W'(1) << 56) - RAD_W'(sq);
    end
  end

  assign valid_o = v_q[2];
  assign args_o  = args3_q;
  assign rad_o   = rad_q;

endmodule
`default_nettype wire

/* rtl/core/qte_isqrt.sv */
// floor square root, one root bit per stage, with the atan2 arguments alongside
`default_nettype none
module qte_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qte_pkg::RAD_W-1:0]     rad_i,
  input  qte_pkg::args_t                args_i,
  output logic                          valid_o,
  output logic [qte_pkg::ROOT_BITS-1:0] root_o,
  output qte_pkg::args_t                args_o
);
  import qte_pkg::*;

  logic [SQ_W-1:0] n_in [ROOT_BITS];
  logic [SQ_W-1:0] r_in [ROOT_BITS];
  args_t           a_in [ROOT_BITS];
  logic [SQ_W-1:0] n_q  [ROOT_BITS];
  logic [SQ_W-1:0] r_q  [ROOT_BITS];
  args_t           a_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] v_q;

  assign n_in[0] = SQ_W'(rad_i);
  assign r_in[0] = '0;
  assign a_in[0] = args_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ROOT_BITS-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_BITS - 1 - j));
    logic [SQ_W-1:0] t;
    if (j > 0) begin : g_link
      assign n_in[j] = n_q[j-1];
      assign r_in[j] = r_q[j-1];
      assign a_in[j] = a_q[j-1];
    end
    assign t = r_in[j] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[j] <= a_in[j];
        if (n_in[j] >= t) begin
          n_q[j] <= n_in[j] - t;
          r_q[j] <= (r_in[j] >> 1) + BIT;
        end else begin
          n_q[j] <= n_in[j];
          r_q[j] <= r_in[j] >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[ROOT_BITS-1];
  assign root_o  = r_q[ROOT_BITS-1][ROOT_BITS-1:0];
  assign args_o  = a_q[ROOT_BITS-1];

endmodule
`default_nettype wire

/* rtl/core/qte_cordic.sv */
// pipelined cordic vectoring atan2 with rounding and saturation to 1/128 degree
`default_nettype none
module qte_cordic #(
  parameter int STEPS = 16,
  parameter int LIM   = 23040,
  parameter int OUT_W = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [qte_pkg::ARG_W-1:0] y_i,
  input  logic signed [qte_pkg::ARG_W-1:0] x_i,
  output logic                             valid_o,
  output logic signed [OUT_W-1:0]          angle_o
);
  import qte_pkg::*;

  localparam int N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

  logic [N+1:0] v_q;
  logic signed [XW-1:0] x_in [N+1];
  logic signed [XW-1:0] y_in [N+1];
  logic signed [ZW-1:0] z_in [N+1];
  logic                 d_in [N+1];
  logic signed [XW-1:0] x_q  [N];
  logic signed [XW-1:0] y_q  [N];
  logic signed [ZW-1:0] z_q  [N];
  logic                 d_q  [N];

  logic signed [XW-1:0] xe, ye, x0_d, y0_d, x0_q, y0_q;
  logic signed [ZW-1:0] z0_d, z0_q;
  logic                 d0_d, d0_q;
  logic signed [XW-1:0] zr, zs;
  logic signed [OUT_W-1:0] ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N:0], valid_i};
    end
  end

  // axis cases settle at once, left half plane folds by 180 degrees
  assign xe = XW'(x_i);
  assign ye = XW'(y_i);
  always_comb begin
    x0_d = xe;
    y0_d = ye;
    z0_d = '0;
    d0_d = 1'b0;
    if (y_i == '0) begin
      d0_d = 1'b1;
      z0_d = (x_i < 0) ? DEG180 : '0;
    end else if (x_i == '0) begin
      d0_d = 1'b1;
      z0_d = (y_i > 0) ? DEG90 : -DEG90;
    end else if (x_i < 0) begin
      z0_d = (y_i > 0) ? DEG180 : -DEG180;
      x0_d = -xe;
      y0_d = -ye;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      z0_q <= z0_d;
      d0_q <= d0_d;
    end
  end

  assign x_in[0] = x0_q;
  assign y_in[0] = y0_q;
  assign z_in[0] = z0_q;
  assign d_in[0] = d0_q;

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
    assign x_in[i+1] = x_q[i];
    assign y_in[i+1] = y_q[i];
    assign z_in[i+1] = z_q[i];
    assign d_in[i+1] = d_q[i];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[i] <= d_in[i];
        if (!d_in[i] && y_in[i] > 0) begin
          x_q[i] <= x_in[i] + (y_in[i] >>> i);
          y_q[i] <= y_in[i] - (x_in[i] >>> i);
          z_q[i] <= z_in[i] + ANG;
        end else if (!d_in[i] && y_in[i] < 0) begin
          x_q[i] <= x_in[i] - (y_in[i] >>> i);
          y_q[i] <= y_in[i] + (x_in[i] >>> i);
          z_q[i] <= z_in[i] - ANG;
        end else begin
          x_q[i] <= x_in[i];
          y_q[i] <= y_in[i];
          z_q[i] <= z_in[i];
        end
      end
    end
  end

  // round half up to 1/128 degree, then saturate
  assign zr = (XW'(z_in[N]) + XW'(32768)) >>> 16;
  always_comb begin
    if (zr > XW'(LIM)) begin
      zs = XW'(LIM);
    end else if (zr < -XW'(LIM)) begin
      zs = -XW'(LIM);
    end else begin
      zs = zr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= OUT_W'(zs);
    end
  end

  assign valid_o = v_q[N+1];
  assign angle_o = ang_q;

endmodule
`default_nettype wire
